// ===== rtl/core/roq_pkg.sv =====
package roq_pkg;

	// Queue geometry.
	localparam int DEPTH = 32;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int PEND_W = 6;

	// Configuration register map.
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_BASE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MAX = 4'd1;
	localparam logic [31:0] BACKOFF_BASE_RST = 32'd5000;
	localparam logic [31:0] BACKOFF_MAX_RST = 32'd300000;

	// Command opcodes.
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result event codes.
	localparam logic [2:0] EV_QUEUED = 3'd0;
	localparam logic [2:0] EV_DROPPED = 3'd1;
	localparam logic [2:0] EV_EMPTY = 3'd2;
	localparam logic [2:0] EV_LINK_DOWN = 3'd3;
	localparam logic [2:0] EV_NOT_DUE = 3'd4;
	localparam logic [2:0] EV_SENT = 3'd5;
	localparam logic [2:0] EV_FAILED = 3'd6;

	typedef struct packed {
		logic               op;
		logic [31:0]        node_id;
		logic [7:0]         pin;
		logic signed [15:0] temp_centi;
		logic [15:0]        press_hpa;
		logic [15:0]        dust_deci;
		logic [31:0]        now_ms;
		logic               link_up;
		logic               send_ok;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         event_res;
		logic [31:0]        out_node_id;
		logic [7:0]         out_pin;
		logic signed [15:0] out_temp_centi;
		logic [15:0]        out_press_hpa;
		logic [15:0]        out_dust_deci;
		logic [7:0]         out_attempts;
		logic [PEND_W-1:0]  pending;
		logic [31:0]        retry_at_ms;
	} res_t;

	// One queue slot as it is kept in the job memory.
	typedef struct packed {
		logic [31:0]        node_id;
		logic signed [15:0] temp_centi;
		logic [15:0]        press_hpa;
		logic [15:0]        dust_deci;
		logic [7:0]         pin;
		logic [7:0]         tries;
	} job_t;

	localparam int JOB_W = $bits(job_t);

	// Backoff unit request and response.
	typedef struct packed {
		logic       go;
		logic [7:0] tries;
	} bo_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] delay;
	} bo_rsp_t;

endpackage

// ===== rtl/core/roq_ram.sv =====
module roq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port, single registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/roq_backoff.sv =====
module roq_backoff (
	input  logic             clk,
	input  logic             arst_n,
	input  roq_pkg::bo_req_t req,
	input  logic [31:0]      base_ms,
	input  logic [31:0]      cap_ms,
	output roq_pkg::bo_rsp_t rsp
);
	import roq_pkg::*;

	logic        run_q;
	logic        done_q;
	logic [32:0] d_q;
	logic [7:0]  k_q;
	logic [7:0]  n_q;
	logic [31:0] delay_q;
	logic [32:0] cap_w;
	logic        at_end;
	logic        at_cap;
	logic        at_zero;

	// Loop exit conditions for the doubling walk.
	assign cap_w = {1'b0, cap_ms};
	assign at_end = k_q >= n_q;
	assign at_cap = d_q >= cap_w;
	assign at_zero = d_q == 33'd0;

	// Control: run flag and one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q <= 1'b1;
			end else if (run_q && (at_end || at_cap || at_zero)) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: one doubling per cycle until the attempt count is reached or the cap is hit.
	// A zero delay stays zero, so the walk stops early there as well.
	always_ff @(posedge clk) begin
		if (req.go) begin
			d_q <= {1'b0, base_ms};
			k_q <= 8'd1;
			n_q <= req.tries;
		end else if (run_q) begin
			priority if (at_end) begin
				delay_q <= at_cap ? cap_ms : d_q[31:0];
			end else if (at_cap) begin
				delay_q <= cap_ms;
			end else if (at_zero) begin
				delay_q <= 32'd0;
			end else begin
				d_q <= {d_q[31:0], 1'b0};
				k_q <= k_q + 8'd1;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.delay = delay_q;

endmodule

// ===== rtl/core/retry_outbox_queue_with_backoff.sv =====
// Channel   Handshake                      Payload
// cmd       start / busy, taken on start   roq_pkg::cmd_t
//           while busy is low
// res       res_valid, one-cycle strobe    roq_pkg::res_t
// cfg       cfg_valid / cfg_ready          cfg_index, cfg_data
//
// For an enqueue and for a tick that sends nothing, the result strobes in the cycle after the item is taken.
// A successful send first reads the head slot from the job memory, then forms the result in S_SEND.
// A failed send also reads the head slot, writes it back with one more attempt and starts the iterative
// backoff unit; the result strobes once the delay is ready, after at most 32 doublings reach the cap.
// Reset clears the pointers and the due state; the job memory is not cleared.
// The receiver cannot stall; cfg_ready is always high.
module retry_outbox_queue_with_backoff (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  roq_pkg::cmd_t                    cmd,
	output logic                             res_valid,
	output roq_pkg::res_t                    res,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [roq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [31:0]                      cfg_data
);
	import roq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SEND = 3'b010,
		S_WAIT = 3'b100
	} state_t;

	state_t             state_q, state_d;
	cmd_t               cmd_q;
	logic [PTR_W-1:0]   head_q, head_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [31:0]        deadline_q, deadline_d;
	logic               waiting_q, waiting_d;
	logic [31:0]        base_q;
	logic [31:0]        max_q;
	res_t               res_q, res_d;
	logic               res_valid_q, res_valid_d;

	logic               accept;
	logic               full;
	logic [PTR_W-1:0]   head_nx;
	logic [PTR_W:0]     tail_sum;
	logic [PTR_W-1:0]   tail;
	logic [PTR_W-1:0]   slot;
	logic [31:0]        due_diff;
	logic               not_due;
	job_t               job_in;
	job_t               job_rd;
	job_t               job_wb;
	logic [7:0]         tries_nx;

	logic               ram_we;
	logic [PTR_W-1:0]   ram_waddr;
	logic [JOB_W-1:0]   ram_wdata;
	logic               ram_re;
	logic [JOB_W-1:0]   ram_rdata;

	bo_req_t            bo_req;
	bo_rsp_t            bo_rsp;

	// Job memory, one slot per queue entry.
	roq_ram #(
		.WIDTH(JOB_W),
		.DEPTH(DEPTH)
	) u_jobs (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	// Retry delay computation.
	roq_backoff u_backoff (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (bo_req),
		.base_ms(base_q),
		.cap_ms (max_q),
		.rsp    (bo_rsp)
	);

	assign busy = state_q != S_IDLE;
	assign accept = start && !busy;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res = res_q;

	// Ring pointer arithmetic.
	assign full = count_q == CNT_W'(DEPTH);
	assign head_nx = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
	assign tail_sum = (PTR_W + 1)'(head_q) + (PTR_W + 1)'(count_q);
	assign tail = (tail_sum >= (PTR_W + 1)'(DEPTH)) ?
		PTR_W'(tail_sum - (PTR_W + 1)'(DEPTH)) : PTR_W'(tail_sum);
	// When full, the oldest entry is dropped and its slot is reused.
	assign slot = full ? head_q : tail;

	// A waiting head is not yet due while now minus its deadline is negative.
	assign due_diff = cmd.now_ms - deadline_q;
	assign not_due = waiting_q && due_diff[31];

	// Slot images for a new job and for a failed head.
	assign job_rd = job_t'(ram_rdata);
	assign tries_nx = job_rd.tries + 8'd1;

	always_comb begin
		job_in.node_id = cmd.node_id;
		job_in.temp_centi = cmd.temp_centi;
		job_in.press_hpa = cmd.press_hpa;
		job_in.dust_deci = cmd.dust_deci;
		job_in.pin = cmd.pin;
		job_in.tries = 8'd0;
		job_wb = job_rd;
		job_wb.tries = tries_nx;
	end

	// Sequencer: next state, memory access and result.
	always_comb begin
		state_d = state_q;
		head_d = head_q;
		count_d = count_q;
		deadline_d = deadline_q;
		waiting_d = waiting_q;
		res_d = '0;
		res_valid_d = 1'b0;
		ram_we = 1'b0;
		ram_waddr = head_q;
		ram_wdata = JOB_W'(job_wb);
		ram_re = 1'b0;
		bo_req = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd.op == OP_ENQUEUE) begin
						ram_we = 1'b1;
						ram_waddr = slot;
						ram_wdata = JOB_W'(job_in);
						res_valid_d = 1'b1;
						if (full) begin
							head_d = head_nx;
							waiting_d = 1'b0;
							deadline_d = 32'd0;
							res_d.event_res = EV_DROPPED;
						end else begin
							count_d = count_q + CNT_W'(1);
							res_d.event_res = EV_QUEUED;
						end
						res_d.pending = PEND_W'(count_d);
					end else begin
						ram_re = 1'b1;
						res_d.pending = PEND_W'(count_q);
						priority if (count_q == '0) begin
							res_valid_d = 1'b1;
							res_d.event_res = EV_EMPTY;
						end else if (!cmd.link_up) begin
							res_valid_d = 1'b1;
							res_d.event_res = EV_LINK_DOWN;
						end else if (not_due) begin
							res_valid_d = 1'b1;
							res_d.event_res = EV_NOT_DUE;
						end else begin
							state_d = S_SEND;
						end
					end
				end
			end
			S_SEND: begin
				res_d.out_node_id = job_rd.node_id;
				res_d.out_pin = job_rd.pin;
				res_d.out_temp_centi = job_rd.temp_centi;
				res_d.out_press_hpa = job_rd.press_hpa;
				res_d.out_dust_deci = job_rd.dust_deci;
				if (cmd_q.send_ok) begin
					head_d = head_nx;
					count_d = count_q - CNT_W'(1);
					waiting_d = 1'b0;
					deadline_d = 32'd0;
					res_valid_d = 1'b1;
					res_d.event_res = EV_SENT;
					res_d.out_attempts = job_rd.tries;
					res_d.pending = PEND_W'(count_d);
					state_d = S_IDLE;
				end else begin
					ram_we = 1'b1;
					ram_waddr = head_q;
					ram_wdata = JOB_W'(job_wb);
					bo_req.go = 1'b1;
					bo_req.tries = tries_nx;
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				if (bo_rsp.done) begin
					deadline_d = cmd_q.now_ms + bo_rsp.delay;
					waiting_d = 1'b1;
					res_valid_d = 1'b1;
					res_d.event_res = EV_FAILED;
					res_d.out_node_id = job_rd.node_id;
					res_d.out_pin = job_rd.pin;
					res_d.out_temp_centi = job_rd.temp_centi;
					res_d.out_press_hpa = job_rd.press_hpa;
					res_d.out_dust_deci = job_rd.dust_deci;
					res_d.out_attempts = tries_nx;
					res_d.pending = PEND_W'(count_q);
					res_d.retry_at_ms = deadline_d;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			count_q <= '0;
			deadline_q <= 32'd0;
			waiting_q <= 1'b0;
			res_valid_q <= 1'b0;
			base_q <= BACKOFF_BASE_RST;
			max_q <= BACKOFF_MAX_RST;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			count_q <= count_d;
			deadline_q <= deadline_d;
			waiting_q <= waiting_d;
			res_valid_q <= res_valid_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_BACKOFF_BASE) begin
					base_q <= cfg_data;
				end else if (cfg_index == CFG_BACKOFF_MAX) begin
					max_q <= cfg_data;
				end
			end
		end
	end

	// Payload registers: the accepted item and the result.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		res_q <= res_d;
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds depth");

	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("job memory read and write in the same cycle");

	a_enq_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.op == OP_ENQUEUE |=> res_valid_q)
		else $error("enqueue item produced no result in the next cycle");

	a_wait_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		waiting_q |-> count_q != '0)
		else $error("head deadline pending on an empty queue");

	a_bo_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		bo_rsp.done |-> state_q == S_WAIT)
		else $error("backoff finished outside of the wait state");
`endif

endmodule
